>>> src/qch_pkg.sv
// Package with payload types, codes and constants of the quality covariate histogram.
`timescale 1ns / 1ps
package qch_pkg;

    typedef struct packed {
        logic              mode;
        logic [7:0]        base_char;
        logic signed [7:0] quality;
        logic [9:0]        cycle;
        logic signed [7:0] dinuc_code;
        logic [7:0]        matched;
        logic [1:0]        table_select;
        logic [13:0]       read_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] bases_count;
        logic [31:0] miss_count;
    } out_item_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SKIP    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_DINUC   = 2'd3;

    localparam logic [1:0] SEL_TOTAL  = 2'd0;
    localparam logic [1:0] SEL_QUAL   = 2'd1;
    localparam logic [1:0] SEL_QCYC   = 2'd2;
    localparam logic [1:0] SEL_QDIN   = 2'd3;

    localparam logic [1:0] REG_QUAL_BASE  = 2'd0;
    localparam logic [1:0] REG_STAT_FLOOR = 2'd1;
    localparam logic [1:0] REG_CYCLES     = 2'd2;
    localparam logic [1:0] REG_COUNT_N    = 2'd3;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_N = 8'h4E;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;     // capture input item and decode
        logic rd;       // read step (unused by the datapath)
        logic wr;       // write back bumped counters
        logic clr;      // clear sweep step
        logic out_load; // capture result
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic clr_done;
    } dp_stat_t;

endpackage

>>> src/quality_covariate_histogram_top.sv
// Top level of the quality covariate histogram.
`timescale 1ns / 1ps
// Counts sequenced bases into four covariate tables for quality recalibration.
// The s_ channel takes one item per handshake: an add item with status OK
// bumps the base counter and, on a mismatch, the miss counter in the totals,
// per-quality, quality-by-cycle and quality-by-dinuc tables; one with a
// negative dinuc code bumps all but the last. A read item fetches one entry.
// Each item gives exactly one item on the m_ channel with a status and, for
// reads, the two counts. After the accepting edge the counter RAMs are read,
// then the saturating write-back and result load happen together. No new
// item is taken until that read-modify-write through the counter memories ends.
// The result register holds while m_ready is low; the block keeps accepting
// one item and then waits in write-back until the result register frees.
// After reset a clearing pass zeros the counter memories, one entry at a time
// over the largest table rounded up to a power of two, while s_ready stays
// low; APB writes are still taken. Registers lie at byte addresses 0, 4, 8
// and 12.
module quality_covariate_histogram_top #(
    parameter int QUAL_ROWS   = 64,
    parameter int MAX_CYCLES  = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  qch_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output qch_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [6:0] qual_base_reg, stat_floor_reg;
    logic [8:0] cycles_reg;
    logic       count_n_reg;
    qch_pkg::dp_cmd_t  cmd;
    qch_pkg::dp_stat_t stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qual_base_reg   <= '0;
            stat_floor_reg  <= '0;
            cycles_reg      <= 9'd256;
            count_n_reg     <= 1'b1;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                qch_pkg::REG_QUAL_BASE:  qual_base_reg   <= pwdata[6:0];
                qch_pkg::REG_STAT_FLOOR: stat_floor_reg  <= pwdata[6:0];
                qch_pkg::REG_CYCLES:     cycles_reg      <= pwdata[8:0];
                qch_pkg::REG_COUNT_N:    count_n_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            qch_pkg::REG_QUAL_BASE:  prdata = {25'd0, qual_base_reg};
            qch_pkg::REG_STAT_FLOOR: prdata = {25'd0, stat_floor_reg};
            qch_pkg::REG_CYCLES:     prdata = {23'd0, cycles_reg};
            default:                 prdata = {31'd0, count_n_reg};
        endcase
    end

    qch_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .cmd, .stat);

    qch_datapath #(
        .QUAL_ROWS(QUAL_ROWS), .MAX_CYCLES(MAX_CYCLES), .COUNT_WIDTH(COUNT_WIDTH)
    ) u_dp (
        .aclk, .aresetn, .cmd, .stat, .in_item(s_data),
        .qual_base(qual_base_reg), .stat_floor(stat_floor_reg),
        .cycles_in_use(cycles_reg), .count_n_bases(count_n_reg),
        .out_item(m_data));
endmodule

>>> src/qch_ram.sv
// Generic single-port-write RAM with a registered read port.
`timescale 1ns / 1ps
module qch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/qch_datapath.sv
// Datapath: decode, counter memories, saturating bump and result register.
`timescale 1ns / 1ps
module qch_datapath #(
    parameter int QUAL_ROWS   = 64,
    parameter int MAX_CYCLES  = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  qch_pkg::dp_cmd_t    cmd,
    output qch_pkg::dp_stat_t   stat,
    input  qch_pkg::in_item_t   in_item,
    input  logic [6:0]          qual_base,
    input  logic [6:0]          stat_floor,
    input  logic [8:0]          cycles_in_use,
    input  logic                count_n_bases,
    output qch_pkg::out_item_t  out_item
);
    localparam int QW  = $clog2(QUAL_ROWS);
    localparam int QCD = QUAL_ROWS * MAX_CYCLES;
    localparam int QCW = $clog2(QCD);
    localparam int QDD = QUAL_ROWS * 16;
    localparam int QDW = $clog2(QDD);
    localparam int SW  = $clog2(MAX_CYCLES + 1);
    localparam int CLRW = ((QCW > QDW) ? QCW : QDW) + 1;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    // Decoded input item.
    logic [QW-1:0]          row_reg;
    logic [QCW-1:0]         qc_idx_reg;
    logic [QDW-1:0]         qd_idx_reg;
    logic                   miss_reg;
    logic                   do_add_reg;
    logic                   do_din_reg;
    logic                   mode_reg;
    logic [1:0]             sel_reg;
    logic                   idx_ok_reg;
    logic [1:0]             status_reg;
    logic [CLRW-1:0]        clr_reg;

    // Total counters in flops.
    logic [COUNT_WIDTH-1:0] tot_b_reg, tot_m_reg;

    // Decode (combinational on held input item).
    logic                   letter_ok;
    logic signed [8:0]      rowv;
    logic [SW-1:0]          stride;
    logic                   row_ok, cyc_ok;
    logic [1:0]             st_next;
    logic [QCW-1:0]         qc_calc;
    logic [13:0]            ridx;
    logic                   idx_ok;

    always_comb begin
        letter_ok = (in_item.base_char == qch_pkg::CHAR_A) ||
                    (in_item.base_char == qch_pkg::CHAR_C) ||
                    (in_item.base_char == qch_pkg::CHAR_G) ||
                    (in_item.base_char == qch_pkg::CHAR_T) ||
                    ((in_item.base_char == qch_pkg::CHAR_N) && count_n_bases);
        rowv   = 9'(in_item.quality) - $signed({2'b00, qual_base});
        stride = (32'(cycles_in_use) > MAX_CYCLES) ? SW'(MAX_CYCLES) : SW'(cycles_in_use);
        row_ok = (rowv >= 0) && (rowv < QUAL_ROWS);
        cyc_ok = 32'(in_item.cycle) < 32'(stride);
        qc_calc = QCW'(QCW'(rowv[QW-1:0]) * QCW'(stride) + QCW'(in_item.cycle));
        if (!letter_ok) begin
            st_next = qch_pkg::ST_SKIP;
        end else if (in_item.quality < $signed({1'b0, stat_floor})) begin
            st_next = qch_pkg::ST_SKIP;
        end else if (!row_ok || !cyc_ok) begin
            st_next = qch_pkg::ST_RANGE;
        end else if (in_item.dinuc_code[7] || in_item.dinuc_code > 8'sd15) begin
            st_next = qch_pkg::ST_DINUC;
        end else begin
            st_next = qch_pkg::ST_OK;
        end
        ridx = in_item.read_index;
        case (in_item.table_select)
            qch_pkg::SEL_TOTAL: idx_ok = (ridx == 14'd0);
            qch_pkg::SEL_QUAL:  idx_ok = 32'(ridx) < QUAL_ROWS;
            qch_pkg::SEL_QCYC:  idx_ok = 32'(ridx) < QCD;
            qch_pkg::SEL_QDIN:  idx_ok = 32'(ridx) < QDD;
            default:            idx_ok = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg   <= in_item.mode;
            sel_reg    <= in_item.table_select;
            idx_ok_reg <= idx_ok;
            miss_reg   <= (in_item.matched == 8'd0);
            row_reg    <= in_item.mode ? QW'(ridx) : rowv[QW-1:0];
            qc_idx_reg <= in_item.mode ? QCW'(ridx) : qc_calc;
            qd_idx_reg <= in_item.mode ? QDW'(ridx)
                                       : {rowv[QW-1:0], in_item.dinuc_code[3:0]};
            do_add_reg <= !in_item.mode && (st_next == qch_pkg::ST_OK ||
                          (st_next == qch_pkg::ST_DINUC && in_item.dinuc_code[7]));
            do_din_reg <= !in_item.mode && (st_next == qch_pkg::ST_OK);
            status_reg <= in_item.mode ? (idx_ok ? qch_pkg::ST_OK : qch_pkg::ST_RANGE)
                                       : st_next;
        end
    end

    // Memories.
    logic                   clearing;
    logic [COUNT_WIDTH-1:0] qb_q, qm_q, cb_q, cm_q, db_q, dm_q;
    logic                   we_q, we_c, we_d;

    assign clearing = !clr_reg[CLRW-1];
    assign stat.clr_done = !clearing;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v,
                                                       input logic en);
        sat_inc = (en && v != CMAX) ? v + 1'b1 : v;
    endfunction

    assign we_q = cmd.clr || (cmd.wr && do_add_reg);
    assign we_c = cmd.clr || (cmd.wr && do_add_reg);
    assign we_d = cmd.clr || (cmd.wr && do_din_reg);

    qch_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(QUAL_ROWS)) u_qb (
        .aclk, .we(we_q), .waddr(cmd.clr ? QW'(clr_reg) : row_reg),
        .wdata(cmd.clr ? '0 : sat_inc(qb_q, 1'b1)), .raddr(row_reg), .rdata(qb_q));
    qch_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(QUAL_ROWS)) u_qm (
        .aclk, .we(we_q), .waddr(cmd.clr ? QW'(clr_reg) : row_reg),
        .wdata(cmd.clr ? '0 : sat_inc(qm_q, miss_reg)), .raddr(row_reg), .rdata(qm_q));
    qch_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(QCD)) u_cb (
        .aclk, .we(we_c), .waddr(cmd.clr ? clr_reg[QCW-1:0] : qc_idx_reg),
        .wdata(cmd.clr ? '0 : sat_inc(cb_q, 1'b1)), .raddr(qc_idx_reg), .rdata(cb_q));
    qch_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(QCD)) u_cm (
        .aclk, .we(we_c), .waddr(cmd.clr ? clr_reg[QCW-1:0] : qc_idx_reg),
        .wdata(cmd.clr ? '0 : sat_inc(cm_q, miss_reg)), .raddr(qc_idx_reg), .rdata(cm_q));
    qch_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(QDD)) u_db (
        .aclk, .we(we_d), .waddr(cmd.clr ? QDW'(clr_reg) : qd_idx_reg),
        .wdata(cmd.clr ? '0 : sat_inc(db_q, 1'b1)), .raddr(qd_idx_reg), .rdata(db_q));
    qch_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(QDD)) u_dm (
        .aclk, .we(we_d), .waddr(cmd.clr ? QDW'(clr_reg) : qd_idx_reg),
        .wdata(cmd.clr ? '0 : sat_inc(dm_q, miss_reg)), .raddr(qd_idx_reg), .rdata(dm_q));

    // Clear sweep covers the largest memory; smaller ones wrap harmlessly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg   <= '0;
            tot_b_reg <= '0;
            tot_m_reg <= '0;
        end else begin
            if (cmd.clr) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.wr && do_add_reg) begin
                tot_b_reg <= sat_inc(tot_b_reg, 1'b1);
                tot_m_reg <= sat_inc(tot_m_reg, miss_reg);
            end
        end
    end

    function automatic logic [31:0] clip(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        clip = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    logic [COUNT_WIDTH-1:0] sb, sm;
    always_comb begin
        case (sel_reg)
            qch_pkg::SEL_TOTAL: begin sb = tot_b_reg; sm = tot_m_reg; end
            qch_pkg::SEL_QUAL:  begin sb = qb_q; sm = qm_q; end
            qch_pkg::SEL_QCYC:  begin sb = cb_q; sm = cm_q; end
            default:            begin sb = db_q; sm = dm_q; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_item.status      <= status_reg;
            out_item.bases_count <= (mode_reg && idx_ok_reg) ? clip(sb) : 32'd0;
            out_item.miss_count  <= (mode_reg && idx_ok_reg) ? clip(sm) : 32'd0;
        end
    end

    logic unused_rd;
    assign unused_rd = cmd.rd;
endmodule

>>> src/qch_ctrl.sv
// Controller: clear sweep, per-item read/write sequencing and handshakes.
`timescale 1ns / 1ps
module qch_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output qch_pkg::dp_cmd_t  cmd,
    input  qch_pkg::dp_stat_t stat
);
    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Output register frees once taken or about to be taken.
    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (stat.clr_done) begin
                    cmd.clr    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) begin
                    cmd.wr       = 1'b1;
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
endmodule

>>> src/qch_checker.sv
// Port-level checker for the quality covariate histogram and its bind.
`timescale 1ns / 1ps
module qch_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input qch_pkg::out_item_t m_data
);
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_no_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted on consecutive cycles");

    a_read_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != qch_pkg::ST_OK |->
        m_data.bases_count == 32'd0 && m_data.miss_count == 32'd0)
        else $error("counts on non-ok result");

    a_miss_le: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.miss_count <= m_data.bases_count)
        else $error("miss count above base count");
endmodule

bind quality_covariate_histogram_top qch_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data);
